// File: src/magnetometer_calibration_assert.svh
// assertion macros shared by the magnetometer calibration rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef MAGNETOMETER_CALIBRATION_ASSERT_SVH
`define MAGNETOMETER_CALIBRATION_ASSERT_SVH

// same-cycle implication
`define MCAL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mcal_pkg.sv
// shared types, widths, register indexes and gain table for the calibration block
// no dependencies
package mcal_pkg;

	localparam int LANES      = 3;
	localparam int RAW_W      = 13;
	localparam int GAIN_W     = 15;
	localparam int PROD_W     = 28;
	localparam int SCALE_W    = 20;
	localparam int BIAS_W     = 20;
	localparam int DEBIAS_W   = 21;
	localparam int COEF_W     = 16;
	localparam int TERM_W     = 37;
	localparam int ACC_W      = 39;
	localparam int CAL_W      = 24;
	localparam int ROW_W      = 48;
	localparam int CFG_ADDR_W = 3;
	localparam int GAIN_SHIFT = 8;
	localparam int MAT_SHIFT  = 14;

	localparam logic [2:0]       RANGE_RESET = 3'd1;
	localparam logic [ROW_W-1:0] ROW_ONE_RESET   = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0] ROW_TWO_RESET   = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0] ROW_THREE_RESET = 48'h4000_0000_0000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RANGE_CODE = 3'd0,
		REG_BIAS_X     = 3'd1,
		REG_BIAS_Y     = 3'd2,
		REG_BIAS_Z     = 3'd3,
		REG_ROW_ONE    = 3'd4,
		REG_ROW_TWO    = 3'd5,
		REG_ROW_THREE  = 3'd6
	} reg_idx_t;

	// per-stage load enables, handed from the top level to lanes and merge
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	// mG per count in unsigned q3.12
	function automatic logic [GAIN_W-1:0] gain_lookup(input logic [2:0] code);
		logic [GAIN_W-1:0] g;
		case (code)
			3'd0: g = 15'd299;
			3'd1: g = 15'd3768;
			3'd2: g = 15'd4997;
			3'd3: g = 15'd6226;
			3'd4: g = 15'd9298;
			3'd5: g = 15'd10486;
			3'd6: g = 15'd12411;
			3'd7: g = 15'd17818;
			default: g = 15'd3768;
		endcase
		return g;
	endfunction

endpackage

// File: src/mcal_lane.sv
// one axis lane: gain scaling with rounding, then hard-iron bias removal
// depends on mcal_pkg
module mcal_lane (
	input  logic                                 clk,
	input  mcal_pkg::pipe_ctl_t                  ctl,
	input  logic signed [mcal_pkg::RAW_W-1:0]    raw,
	input  logic        [mcal_pkg::GAIN_W-1:0]   gain,
	input  logic signed [mcal_pkg::BIAS_W-1:0]   bias,
	output logic signed [mcal_pkg::DEBIAS_W-1:0] dbias_s2
);

	logic signed [mcal_pkg::PROD_W:0]   prod_full;
	logic signed [mcal_pkg::PROD_W-1:0] prod_s1;
	logic signed [mcal_pkg::PROD_W-1:0] rnd;
	logic signed [mcal_pkg::SCALE_W-1:0] scaled;

	assign prod_full = raw * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod_s1 <= prod_full[mcal_pkg::PROD_W-1:0];
		end
	end

	// round to nearest, ties up, into 1/16 mG
	assign rnd    = prod_s1 + 28'sd128;
	assign scaled = rnd[mcal_pkg::PROD_W-1:mcal_pkg::GAIN_SHIFT];

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			dbias_s2 <= {scaled[mcal_pkg::SCALE_W-1], scaled} - {bias[mcal_pkg::BIAS_W-1], bias};
		end
	end

endmodule

// File: src/mcal_merge.sv
// merge stage: soft-iron matrix times the three debiased lane values
// depends on mcal_pkg
module mcal_merge (
	input  logic                                                clk,
	input  mcal_pkg::pipe_ctl_t                                 ctl,
	input  logic [mcal_pkg::LANES-1:0][mcal_pkg::ROW_W-1:0]     rows,
	input  logic [mcal_pkg::LANES-1:0][mcal_pkg::DEBIAS_W-1:0]  dbias,
	output logic [mcal_pkg::LANES-1:0][mcal_pkg::CAL_W-1:0]     cal_s4
);

	logic signed [mcal_pkg::TERM_W-1:0] term_c  [mcal_pkg::LANES][mcal_pkg::LANES];
	logic signed [mcal_pkg::TERM_W-1:0] term_s3 [mcal_pkg::LANES][mcal_pkg::LANES];
	logic signed [mcal_pkg::ACC_W-1:0]  acc_c   [mcal_pkg::LANES];

	for (genvar r = 0; r < mcal_pkg::LANES; r++) begin : g_row
		for (genvar c = 0; c < mcal_pkg::LANES; c++) begin : g_col
			assign term_c[r][c] = $signed(rows[r][mcal_pkg::COEF_W*c +: mcal_pkg::COEF_W])
				* $signed(dbias[c]);

			always_ff @(posedge clk) begin
				if (ctl.en_s3) begin
					term_s3[r][c] <= term_c[r][c];
				end
			end
		end

		// row sum plus half an lsb, then drop the q2.14 fraction
		assign acc_c[r] = 39'(term_s3[r][0]) + 39'(term_s3[r][1]) + 39'(term_s3[r][2])
			+ 39'sd8192;

		always_ff @(posedge clk) begin
			if (ctl.en_s4) begin
				cal_s4[r] <= acc_c[r][mcal_pkg::MAT_SHIFT+mcal_pkg::CAL_W-1:mcal_pkg::MAT_SHIFT];
			end
		end
	end

endmodule

// File: src/magnetometer_calibration.sv
// path: an accepted item passes the s1 product, s2 debias, s3 term and s4 output registers
// throughput: one item per cycle while m_tready is high; each of the four stages holds
// one item and moves on when the stage after it is empty or moving; bubbles close up in stalls
// reset: arst_n clears every stage valid bit and returns the registers to range code 1,
// zero bias and the identity matrix; no clearing pass, items are taken right away
//
// top level of the magnetometer calibration block; depends on mcal_pkg, mcal_lane,
// mcal_merge and magnetometer_calibration_assert.svh
`include "magnetometer_calibration_assert.svh"

module magnetometer_calibration (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_x [12:0], raw_y [25:13], raw_z [38:26], zero [39]
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // cal_x [23:0], cal_y [47:24], cal_z [71:48]
	// configuration write port
	input  logic                              cfg_we,
	input  logic [mcal_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [mcal_pkg::ROW_W-1:0]        cfg_wdata
);

	// configuration registers
	logic [2:0]                                               range_code_q;
	logic [mcal_pkg::LANES-1:0][mcal_pkg::BIAS_W-1:0]         bias_q;
	logic [mcal_pkg::LANES-1:0][mcal_pkg::ROW_W-1:0]          row_q;

	// stage valid bits; v_s4 is the output register
	logic v_s1, v_s2, v_s3, v_s4;
	mcal_pkg::pipe_ctl_t ctl;

	logic [mcal_pkg::GAIN_W-1:0]                              gain;
	logic [mcal_pkg::LANES-1:0][mcal_pkg::DEBIAS_W-1:0]       dbias_s2;
	logic [mcal_pkg::LANES-1:0][mcal_pkg::CAL_W-1:0]          cal_s4;

	// register writes, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_code_q <= mcal_pkg::RANGE_RESET;
			bias_q       <= '0;
			row_q[0]     <= mcal_pkg::ROW_ONE_RESET;
			row_q[1]     <= mcal_pkg::ROW_TWO_RESET;
			row_q[2]     <= mcal_pkg::ROW_THREE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				mcal_pkg::REG_RANGE_CODE: range_code_q <= cfg_wdata[2:0];
				mcal_pkg::REG_BIAS_X:     bias_q[0] <= cfg_wdata[mcal_pkg::BIAS_W-1:0];
				mcal_pkg::REG_BIAS_Y:     bias_q[1] <= cfg_wdata[mcal_pkg::BIAS_W-1:0];
				mcal_pkg::REG_BIAS_Z:     bias_q[2] <= cfg_wdata[mcal_pkg::BIAS_W-1:0];
				mcal_pkg::REG_ROW_ONE:    row_q[0] <= cfg_wdata;
				mcal_pkg::REG_ROW_TWO:    row_q[1] <= cfg_wdata;
				mcal_pkg::REG_ROW_THREE:  row_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its item moves on
	assign ctl.en_s4 = !v_s4 || m_tready;
	assign ctl.en_s3 = !v_s3 || ctl.en_s4;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign ctl.en_s1 = !v_s1 || ctl.en_s2;

	assign s_tready = ctl.en_s1;
	assign m_tvalid = v_s4;
	assign m_tdata  = cal_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= s_tvalid;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	// gain for the current range, shared by all three lanes
	assign gain = mcal_pkg::gain_lookup(range_code_q);

	// one lane per axis: scale and debias
	for (genvar i = 0; i < mcal_pkg::LANES; i++) begin : g_lane
		mcal_lane u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.raw      ($signed(s_tdata[mcal_pkg::RAW_W*i +: mcal_pkg::RAW_W])),
			.gain     (gain),
			.bias     ($signed(bias_q[i])),
			.dbias_s2 (dbias_s2[i])
		);
	end

	// matrix product across lanes, ends in the output register
	mcal_merge u_merge (
		.clk    (clk),
		.ctl    (ctl),
		.rows   (row_q),
		.dbias  (dbias_s2),
		.cal_s4 (cal_s4)
	);

	// an accepted item always lands in the first stage
	`MCAL_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, v_s1, "accepted item lost at stage one")
	// items move from stage one to stage two without loss
	`MCAL_ASSERT_NEXT(a_s1_to_s2, v_s1 && ctl.en_s2, v_s2, "item lost between stage one and two")
	// the output register picks up a moving stage three item
	`MCAL_ASSERT_NEXT(a_s3_to_out, v_s3 && ctl.en_s4, v_s4, "item lost entering output register")
	// back pressure only when every stage is occupied
	`MCAL_ASSERT_SAME(a_full_stall, !s_tready, v_s1 && v_s2 && v_s3 && v_s4, "stall with a free stage")

endmodule
